FILE: src/des_round_function_unit_macros.svh
// Assertion macros for the DES round function unit checker.
`ifndef DES_ROUND_FUNCTION_UNIT_MACROS_SVH
`define DES_ROUND_FUNCTION_UNIT_MACROS_SVH

// same-cycle implication
`define DESRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DESRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/desrf_pkg.sv
// Package: DES round function tables, widths and helper functions.
package desrf_pkg;

    localparam int HALF_W = 32;
    localparam int KEY_W  = 48;
    localparam int IN_W   = 80;
    localparam int OUT_W  = 32;

    typedef logic [HALF_W-1:0] t_half;
    typedef logic [KEY_W-1:0]  t_key;

    localparam logic [5:0] EXPAND_TAB [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] PERM_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [3:0] SBOX_TAB [8][64] = '{
        '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8, 4'd3, 4'd10, 4'd6, 4'd12,
          4'd5, 4'd9, 4'd0, 4'd7,
          4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1, 4'd10, 4'd6, 4'd12, 4'd11,
          4'd9, 4'd5, 4'd3, 4'd8,
          4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11, 4'd15, 4'd12, 4'd9, 4'd7,
          4'd3, 4'd10, 4'd5, 4'd0,
          4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7, 4'd5, 4'd11, 4'd3, 4'd14,
          4'd10, 4'd0, 4'd6, 4'd13},
        '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4, 4'd9, 4'd7, 4'd2, 4'd13,
          4'd12, 4'd0, 4'd5, 4'd10,
          4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14, 4'd12, 4'd0, 4'd1, 4'd10,
          4'd6, 4'd9, 4'd11, 4'd5,
          4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1, 4'd5, 4'd8, 4'd12, 4'd6,
          4'd9, 4'd3, 4'd2, 4'd15,
          4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2, 4'd11, 4'd6, 4'd7, 4'd12,
          4'd0, 4'd5, 4'd14, 4'd9},
        '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5, 4'd1, 4'd13, 4'd12, 4'd7,
          4'd11, 4'd4, 4'd2, 4'd8,
          4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10, 4'd2, 4'd8, 4'd5, 4'd14,
          4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0, 4'd11, 4'd1, 4'd2, 4'd12,
          4'd5, 4'd10, 4'd14, 4'd7,
          4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7, 4'd4, 4'd15, 4'd14, 4'd3,
          4'd11, 4'd5, 4'd2, 4'd12},
        '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10, 4'd1, 4'd2, 4'd8, 4'd5,
          4'd11, 4'd12, 4'd4, 4'd15,
          4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3, 4'd4, 4'd7, 4'd2, 4'd12,
          4'd1, 4'd10, 4'd14, 4'd9,
          4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13, 4'd15, 4'd1, 4'd3, 4'd14,
          4'd5, 4'd2, 4'd8, 4'd4,
          4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8, 4'd9, 4'd4, 4'd5, 4'd11,
          4'd12, 4'd7, 4'd2, 4'd14},
        '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6, 4'd8, 4'd5, 4'd3, 4'd15,
          4'd13, 4'd0, 4'd14, 4'd9,
          4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1, 4'd5, 4'd0, 4'd15, 4'd10,
          4'd3, 4'd9, 4'd8, 4'd6,
          4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8, 4'd15, 4'd9, 4'd12, 4'd5,
          4'd6, 4'd3, 4'd0, 4'd14,
          4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13, 4'd6, 4'd15, 4'd0, 4'd9,
          4'd10, 4'd4, 4'd5, 4'd3},
        '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8, 4'd0, 4'd13, 4'd3, 4'd4,
          4'd14, 4'd7, 4'd5, 4'd11,
          4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5, 4'd6, 4'd1, 4'd13, 4'd14,
          4'd0, 4'd11, 4'd3, 4'd8,
          4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3, 4'd7, 4'd0, 4'd4, 4'd10,
          4'd1, 4'd13, 4'd11, 4'd6,
          4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10, 4'd11, 4'd14, 4'd1, 4'd7,
          4'd6, 4'd0, 4'd8, 4'd13},
        '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13, 4'd3, 4'd12, 4'd9, 4'd7,
          4'd5, 4'd10, 4'd6, 4'd1,
          4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10, 4'd14, 4'd3, 4'd5, 4'd12,
          4'd2, 4'd15, 4'd8, 4'd6,
          4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14, 4'd10, 4'd15, 4'd6, 4'd8,
          4'd0, 4'd5, 4'd9, 4'd2,
          4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7, 4'd9, 4'd5, 4'd0, 4'd15,
          4'd14, 4'd2, 4'd3, 4'd12},
        '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1, 4'd10, 4'd9, 4'd3, 4'd14,
          4'd5, 4'd0, 4'd12, 4'd7,
          4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4, 4'd12, 4'd5, 4'd6, 4'd11,
          4'd0, 4'd14, 4'd9, 4'd2,
          4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2, 4'd0, 4'd6, 4'd10, 4'd13,
          4'd15, 4'd3, 4'd5, 4'd8,
          4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13, 4'd15, 4'd12, 4'd9, 4'd0,
          4'd3, 4'd5, 4'd6, 4'd11}
    };

    // DES bit n sits at position 32-n of a 32-bit word
    function automatic t_key expand(input t_half r);
        t_key       ex;
        logic [5:0] pos;
        for (int i = 0; i < KEY_W; i++) begin
            pos = 6'd32 - EXPAND_TAB[i];
            ex[KEY_W-1-i] = r[pos[4:0]];
        end
        return ex;
    endfunction

    function automatic t_half sbox_all(input t_key x);
        t_half      sb;
        logic [5:0] six;
        for (int i = 0; i < 8; i++) begin
            six = x[KEY_W-1-6*i -: 6];
            sb[HALF_W-1-4*i -: 4] = SBOX_TAB[i][{six[5], six[0], six[4:1]}];
        end
        return sb;
    endfunction

    function automatic t_half permute(input t_half s);
        t_half      p;
        logic [5:0] pos;
        for (int i = 0; i < HALF_W; i++) begin
            pos = 6'd32 - PERM_TAB[i];
            p[HALF_W-1-i] = s[pos[4:0]];
        end
        return p;
    endfunction

endpackage

FILE: src/des_round_function_unit.sv
// Top level: three-stage pipelined DES round (Feistel f) function.
// Stages in order: expansion and key XOR (r_x1), S-box lookup (r_s2), permutation (r_f3).
// Throughput: one request per cycle while the output side accepts every cycle.
// Each stage advances when empty or when the stage after it advances.
// Reset (i_rst_n low, synchronous) drops all in-flight requests.
module des_round_function_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [desrf_pkg::IN_W-1:0]  i_s_tdata,  // right_half[31:0], round_key[79:32]
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [desrf_pkg::OUT_W-1:0] o_m_tdata   // f_result[31:0]
);
    import desrf_pkg::*;

    logic  r_v1, r_v2, r_v3;
    logic  n_v1, n_v2, n_v3;
    t_key  r_x1;
    t_half r_s2, r_f3;
    logic  w_adv1, w_adv2, w_adv3;

    assign w_adv3 = !r_v3 || i_m_tready;
    assign w_adv2 = !r_v2 || w_adv3;
    assign w_adv1 = !r_v1 || w_adv2;

    assign o_s_tready = w_adv1;
    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_f3;

    always_comb begin
        n_v1 = w_adv1 ? i_s_tvalid : r_v1;
        n_v2 = w_adv2 ? r_v1 : r_v2;
        n_v3 = w_adv3 ? r_v2 : r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_x1 <= expand(i_s_tdata[HALF_W-1:0]) ^ i_s_tdata[IN_W-1:HALF_W];
        end
        if (w_adv2) begin
            r_s2 <= sbox_all(r_x1);
        end
        if (w_adv3) begin
            r_f3 <= permute(r_s2);
        end
    end

endmodule

FILE: src/desrf_checker.sv
// Checker: port-level properties of the DES round function unit, with bind.
`include "des_round_function_unit_macros.svh"

module desrf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic [desrf_pkg::IN_W-1:0]  i_s_tdata,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [desrf_pkg::OUT_W-1:0] o_m_tdata
);
    logic w_in_req;
    assign w_in_req = i_s_tvalid && o_s_tready;

    `DESRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata), "stalled result changed")
    `DESRF_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_s_tvalid && !o_s_tready,
        i_s_tvalid && $stable(i_s_tdata), "stalled request changed")
    `DESRF_ASSERT_NOW(a_ready_on_drain, i_clk, i_rst_n, i_m_tready, o_s_tready,
        "input stalled while output drains")
    `DESRF_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready,
        "input stalled with empty output")
    `DESRF_ASSERT_NEXT(a_latency, i_clk, i_rst_n, w_in_req ##1 i_m_tready ##1 i_m_tready,
        o_m_tvalid, "result missing three cycles after request")

endmodule

bind des_round_function_unit desrf_checker u_desrf_checker (.*);

FILE: test/des_round_function_unit_tb.sv
// Self-checking stream testbench for the pipelined DES round function unit.

// Expansion, permutation and S-box contents as published for DES
localparam int E_SEL [48] = '{
    32, 1,  2,  3,  4,  5,  4,  5,  6,  7,  8,  9,
    8,  9,  10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
    16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
    24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1
};

localparam int P_SEL [32] = '{
    16, 7,  20, 21, 29, 12, 28, 17, 1,  15, 23, 26, 5,  18, 31, 10,
    2,  8,  24, 14, 32, 27, 3,  9,  19, 13, 30, 6,  22, 11, 4,  25
};

// four rows per box, column 0 in the top nibble
localparam logic [63:0] S_ROWS [32] = '{
    64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538, 64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D,
    64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5, 64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9,
    64'hA09E63F51DC7B428, 64'hD709346A285ECBF1, 64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C,
    64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9, 64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E,
    64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986, 64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453,
    64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38, 64'h9EF528C3704A1DB6, 64'h432C95FABE17608D,
    64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86, 64'h14BDC37EAF680592, 64'h6BD814A7950FE23C,
    64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92, 64'h7B419CE206ADF358, 64'h21E74A8DFC90356B
};

class f_result_board;
    logic [31:0] f_result_q [$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    function logic [31:0] round_f(logic [31:0] r, logic [47:0] k);
        logic [47:0] mixed;
        logic [31:0] sb;
        logic [31:0] res;
        logic [5:0]  six;
        logic [63:0] row_bits;
        int          col;
        for (int i = 0; i < 48; i++) mixed[47-i] = r[32-E_SEL[i]];
        mixed = mixed ^ k;
        for (int i = 0; i < 8; i++) begin
            six      = mixed[47-6*i -: 6];
            row_bits = S_ROWS[4*i + {six[5], six[0]}];
            col      = int'(six[4:1]);
            sb[31-4*i -: 4] = row_bits[63-4*col -: 4];
        end
        for (int i = 0; i < 32; i++) res[31-i] = sb[32-P_SEL[i]];
        return res;
    endfunction

    function void note_request(logic [31:0] r, logic [47:0] k);
        f_result_q.push_back(round_f(r, k));
    endfunction

    function void check_result(logic [31:0] got);
        logic [31:0] want;
        if (f_result_q.size() == 0) begin
            $error("f_result: unexpected result, actual %08h", got);
            errors++;
            return;
        end
        want = f_result_q.pop_front();
        if (got !== want) begin
            $error("f_result mismatch: expected %08h, actual %08h", want, got);
            errors++;
        end
    endfunction
endclass

module des_round_function_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 200000;

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_s_tvalid = 1'b0;
    logic                        o_s_tready;
    logic [desrf_pkg::IN_W-1:0]  i_s_tdata  = '0;   // right_half[31:0], round_key[79:32]
    logic                        o_m_tvalid;
    logic                        i_m_tready = 1'b0;
    logic [desrf_pkg::OUT_W-1:0] o_m_tdata;         // f_result[31:0]

    f_result_board board = new();
    bit            calm;
    bit            hold_off_req;
    int            cycles;

    des_round_function_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_result(o_m_tdata);
    end

    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (80) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic send_request(input logic [31:0] r, input logic [47:0] k);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {k, r};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_request(r, k);
    endtask

    task automatic offer(input logic [31:0] r, input logic [47:0] k);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        send_request(r, k);
    endtask

    function automatic logic [31:0] pick_half();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) return 32'h1 << $urandom_range(0, 31);
        if (mode == 1) return ~(32'h1 << $urandom_range(0, 31));
        return $urandom;
    endfunction

    function automatic logic [47:0] pick_key();
        logic [47:0] k;
        int          mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) return 48'h1 << $urandom_range(0, 47);
        if (mode == 1) return ~(48'h1 << $urandom_range(0, 47));
        k[47:32] = 16'($urandom_range(0, 16'hFFFF));
        k[31:0]  = $urandom;
        return k;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(32'h0, 48'h0);
        offer('1, '1);
        offer('1, 48'h0);
        offer(32'h0, '1);
        offer(32'hAAAAAAAA, 48'h555555555555);
        offer(32'h55555555, 48'hAAAAAAAAAAAA);
        offer(32'h80000000, 48'h0);
        offer(32'h00000001, 48'h0);
        offer(32'h0, 48'h800000000000);
        offer(32'h0, 48'h000000000001);
        offer(32'h0, {8{6'b100001}});
        offer(32'h0, {8{6'b011110}});
        offer(32'h0, {8{6'b011111}});
        offer(32'h0, {8{6'b100000}});
        offer(32'hFFFF0000, 48'h0);
        offer(32'h0000FFFF, 48'hFFFFFF000000);
        offer(32'h12345678, 48'h0123456789AB);

        for (int n = 0; n < 850; n++) begin
            if (n == 150) hold_off_req = 1'b1;
            if (n == 400) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (board.f_result_q.size() != 0) @(posedge i_clk);
            end
            if (n == 730) calm = 1'b1;
            offer(pick_half(), pick_key());
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.f_result_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: des_round_function_unit.f
+incdir+src
src/desrf_pkg.sv
src/des_round_function_unit.sv
src/desrf_checker.sv
test/des_round_function_unit_tb.sv
